[design/pfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

  // most length bytes a frame may carry
  localparam int unsigned LEN_GROUPS = 3;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 21;
  localparam int unsigned GROUP_W = 7;

  localparam logic [BYTE_W-1:0]  START_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0]  STOP_BYTE  = 8'h55;
  localparam logic [BYTE_W-1:0]  CRC_POLY   = 8'h8C;
  localparam logic [BYTE_W-1:0]  GROUP_MASK = 8'h7F;
  localparam logic [BYTE_W-1:0]  MORE_BIT   = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_BUSY  = 3'd1,
    ST_VALID = 3'd2,
    ST_CRC   = 3'd3,
    ST_STOP  = 3'd4,
    ST_LEN   = 3'd5
  } pfr_status_t;

  typedef enum logic [7:0] {
    PH_HUNT = 8'b0000_0001,
    PH_FROM = 8'b0000_0010,
    PH_TO   = 8'b0000_0100,
    PH_CMD  = 8'b0000_1000,
    PH_LEN  = 8'b0001_0000,
    PH_DATA = 8'b0010_0000,
    PH_CRC  = 8'b0100_0000,
    PH_STOP = 8'b1000_0000
  } pfr_phase_t;

  // one status request toward the result register
  typedef struct packed {
    pfr_status_t       status;
    logic [BYTE_W-1:0] from_addr;
    logic [BYTE_W-1:0] to_addr;
    logic [BYTE_W-1:0] command;
    logic [LEN_W-1:0]  payload_length;
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
  } pfr_result_t;

endpackage

`default_nettype wire

[design/pfr_crc8.sv]
`timescale 1ns / 1ps
`default_nettype none

// one byte of reflected crc-8, unrolled over the eight bits
module pfr_crc8 (
  input  wire logic [pfr_pkg::BYTE_W-1:0] crc_in,
  input  wire logic [pfr_pkg::BYTE_W-1:0] data_in,
  output logic      [pfr_pkg::BYTE_W-1:0] crc_out
);

  always_comb begin
    logic [pfr_pkg::BYTE_W-1:0] c;
    logic [pfr_pkg::BYTE_W-1:0] d;
    logic                       mix;
    c = crc_in;
    d = data_in;
    for (int i = 0; i < pfr_pkg::BYTE_W; i++) begin
      mix = c[0] ^ d[0];
      c   = c >> 1;
      if (mix) begin
        c = c ^ pfr_pkg::CRC_POLY;
      end
      d = d >> 1;
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

[design/pfr_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

// frame state and the per-byte step
module pfr_parser (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step_en,
  input  wire logic [pfr_pkg::BYTE_W-1:0]  rx_byte,
  output pfr_pkg::pfr_result_t             result
);

  pfr_pkg::pfr_phase_t             phase_r, phase_nxt;
  logic [pfr_pkg::BYTE_W-1:0]      crc_r, crc_nxt;
  logic [pfr_pkg::BYTE_W-1:0]      sender_r, sender_nxt;
  logic [pfr_pkg::BYTE_W-1:0]      receiver_r, receiver_nxt;
  logic [pfr_pkg::BYTE_W-1:0]      opcode_r, opcode_nxt;
  logic [pfr_pkg::LEN_W-1:0]       len_r, len_nxt;
  logic [pfr_pkg::LEN_W-1:0]       cnt_r, cnt_nxt;
  logic [pfr_pkg::BYTE_W-1:0]      crc_step;
  logic [pfr_pkg::LEN_W-1:0]       group;
  logic [pfr_pkg::LEN_W-1:0]       group_sh;
  logic [pfr_pkg::LEN_W-1:0]       cnt_inc;
  logic                            frame_end;
  pfr_pkg::pfr_status_t            status;
  logic                            dvalid;
  logic [pfr_pkg::BYTE_W-1:0]      dbyte;

  pfr_crc8 u_crc8 (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_step)
  );

  assign group   = pfr_pkg::LEN_W'(rx_byte & pfr_pkg::GROUP_MASK);
  assign cnt_inc = cnt_r + pfr_pkg::LEN_W'(1);

  // groups past the top of the length field are dropped
  always_comb begin
    case (cnt_r)
      pfr_pkg::LEN_W'(0): group_sh = group;
      pfr_pkg::LEN_W'(1): group_sh = group << pfr_pkg::GROUP_W;
      pfr_pkg::LEN_W'(2): group_sh = group << (2 * pfr_pkg::GROUP_W);
      default:            group_sh = '0;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    crc_nxt      = crc_r;
    sender_nxt   = sender_r;
    receiver_nxt = receiver_r;
    opcode_nxt   = opcode_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    status       = pfr_pkg::ST_BUSY;
    dvalid       = 1'b0;
    dbyte        = '0;
    frame_end    = 1'b0;
    case (phase_r)
      pfr_pkg::PH_HUNT: begin
        if (rx_byte == pfr_pkg::START_BYTE) begin
          crc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = pfr_pkg::PH_FROM;
        end
      end
      pfr_pkg::PH_FROM: begin
        sender_nxt = rx_byte;
        crc_nxt    = crc_step;
        phase_nxt  = pfr_pkg::PH_TO;
      end
      pfr_pkg::PH_TO: begin
        receiver_nxt = rx_byte;
        crc_nxt      = crc_step;
        phase_nxt    = pfr_pkg::PH_CMD;
      end
      pfr_pkg::PH_CMD: begin
        opcode_nxt = rx_byte;
        crc_nxt    = crc_step;
        cnt_nxt    = '0;
        phase_nxt  = pfr_pkg::PH_LEN;
      end
      pfr_pkg::PH_LEN: begin
        if (cnt_r >= pfr_pkg::LEN_W'(pfr_pkg::LEN_GROUPS)) begin
          status    = pfr_pkg::ST_LEN;
          frame_end = 1'b1;
        end else begin
          len_nxt = len_r | group_sh;
          cnt_nxt = cnt_inc;
          crc_nxt = crc_step;
          if ((rx_byte & pfr_pkg::MORE_BIT) == '0) begin
            cnt_nxt   = '0;
            phase_nxt = (len_nxt == '0) ? pfr_pkg::PH_CRC : pfr_pkg::PH_DATA;
          end
        end
      end
      pfr_pkg::PH_DATA: begin
        dvalid  = 1'b1;
        dbyte   = rx_byte;
        crc_nxt = crc_step;
        if (cnt_inc == len_r) begin
          cnt_nxt   = '0;
          phase_nxt = pfr_pkg::PH_CRC;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      pfr_pkg::PH_CRC: begin
        crc_nxt = crc_step;
        if (crc_step != '0) begin
          status    = pfr_pkg::ST_CRC;
          frame_end = 1'b1;
        end else begin
          phase_nxt = pfr_pkg::PH_STOP;
        end
      end
      pfr_pkg::PH_STOP: begin
        status    = (rx_byte == pfr_pkg::STOP_BYTE) ? pfr_pkg::ST_VALID : pfr_pkg::ST_STOP;
        frame_end = 1'b1;
      end
      default: begin
        phase_nxt = pfr_pkg::PH_HUNT;
      end
    endcase
    if (!frame_end && phase_nxt == pfr_pkg::PH_HUNT) begin
      status = pfr_pkg::ST_IDLE;
    end
  end

  // fields show the frame as it stands after this byte, before any clearing
  assign result.status         = status;
  assign result.from_addr      = sender_nxt;
  assign result.to_addr        = receiver_nxt;
  assign result.command        = opcode_nxt;
  assign result.payload_length = len_nxt;
  assign result.data_valid     = dvalid;
  assign result.data_byte      = dbyte;

  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && frame_end)) begin
      phase_r    <= pfr_pkg::PH_HUNT;
      crc_r      <= '0;
      sender_r   <= '0;
      receiver_r <= '0;
      opcode_r   <= '0;
      len_r      <= '0;
      cnt_r      <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      crc_r      <= crc_nxt;
      sender_r   <= sender_nxt;
      receiver_r <= receiver_nxt;
      opcode_r   <= opcode_nxt;
      len_r      <= len_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[design/packet_frame_receiver_crc8.sv]
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial frame receiver. Each request on the in_ channel carries one raw
// byte from the link and yields exactly one request on the out_ channel, in
// order: a status (idle, in progress, frame valid, crc error, stop error,
// length error), the captured from/to/command bytes and decoded length of the
// current frame, and the byte itself flagged by out_data_valid when it is a
// payload byte. Frames open with 0xAA, carry a little-endian 7-bit-group
// length of at most pfr_pkg::LEN_GROUPS bytes, a crc-8 (reflected 0x8C, init
// 0) over from byte through crc byte that must leave zero, and close with
// 0x55. Payload is streamed, never buffered. One byte is taken per clock when
// the out_ side keeps up. A taken byte sits in the input register, and the
// frame step moves it into the result register once that register is free
// or being drained. The frame state update is the loop that sets this rate.
module packet_frame_receiver_crc8 (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // received bytes
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_rx_byte,
  // per-byte status
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [2:0]                       out_status,
  output logic [7:0]                       out_from_addr,
  output logic [7:0]                       out_to_addr,
  output logic [7:0]                       out_command,
  output logic [20:0]                      out_payload_length,
  output logic                             out_data_valid,
  output logic [7:0]                       out_data_byte
);

  // input register
  logic                           in_vld_r;
  logic [pfr_pkg::BYTE_W-1:0]     in_byte_r;
  // result register
  logic                           out_vld_r;
  pfr_pkg::pfr_result_t           out_res_r;
  pfr_pkg::pfr_result_t           step_res;

  logic in_take;
  logic advance;

  // a byte moves into the result register whenever that register is free
  // or being drained this cycle
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // frame state machine, stepped once per byte leaving the input register
  pfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .rx_byte (in_byte_r),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_res_r.status;
  assign out_from_addr      = out_res_r.from_addr;
  assign out_to_addr        = out_res_r.to_addr;
  assign out_command        = out_res_r.command;
  assign out_payload_length = out_res_r.payload_length;
  assign out_data_valid     = out_res_r.data_valid;
  assign out_data_byte      = out_res_r.data_byte;

endmodule

`default_nettype wire

[design/pfr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module pfr_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  out_status,
  input  wire logic [7:0]  out_from_addr,
  input  wire logic [7:0]  out_to_addr,
  input  wire logic [7:0]  out_command,
  input  wire logic [20:0] out_payload_length,
  input  wire logic        out_data_valid,
  input  wire logic [7:0]  out_data_byte
);

  // stalled byte request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("stalled byte request changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_payload_length) && $stable(out_data_byte))
    else $error("stalled result changed");

  // payload bytes only occur inside a frame
  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> out_status == pfr_pkg::ST_BUSY)
    else $error("payload byte outside frame");

  // idle means no frame captured
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pfr_pkg::ST_IDLE |->
      out_from_addr == '0 && out_to_addr == '0 && out_command == '0 &&
      out_payload_length == '0 && !out_data_valid)
    else $error("idle status with frame fields set");

  // non-payload results carry a zero byte
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data_valid |-> out_data_byte == '0)
    else $error("data byte set without data valid");

endmodule

bind packet_frame_receiver_crc8 pfr_checker u_pfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_rx_byte         (in_rx_byte),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_from_addr      (out_from_addr),
  .out_to_addr        (out_to_addr),
  .out_command        (out_command),
  .out_payload_length (out_payload_length),
  .out_data_valid     (out_data_valid),
  .out_data_byte      (out_data_byte)
);

`default_nettype wire

[verif/frame_status_checker.sv]
`timescale 1ns / 1ps

// crc-8, reflected poly, one byte folded in lsb first
package frame_crc_pkg;

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = crc;
    d = b;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ d[0];
      c = c >> 1;
      if (mix) begin
        c = c ^ pfr_pkg::CRC_POLY;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

module frame_status_checker
  import pfr_pkg::*;
  import frame_crc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [7:0]  out_from_addr,
  input  logic [7:0]  out_to_addr,
  input  logic [7:0]  out_command,
  input  logic [20:0] out_payload_length,
  input  logic        out_data_valid,
  input  logic [7:0]  out_data_byte,
  output int          mismatches,
  output int          pending,
  output int          checked,
  output int          frames_good,
  output int          frames_bad
);

  // receiver state as predicted
  pfr_phase_t        rx_phase;
  logic [BYTE_W-1:0] rx_crc;
  logic [BYTE_W-1:0] rx_from;
  logic [BYTE_W-1:0] rx_to;
  logic [BYTE_W-1:0] rx_cmd;
  logic [LEN_W-1:0]  rx_len;
  logic [LEN_W-1:0]  rx_count;

  pfr_result_t status_due[$];
  int          n_fail;
  int          n_checked;
  int          n_good;
  int          n_bad;

  function automatic void clear_receiver();
    rx_phase = PH_HUNT;
    rx_crc   = '0;
    rx_from  = '0;
    rx_to    = '0;
    rx_cmd   = '0;
    rx_len   = '0;
    rx_count = '0;
  endfunction

  function automatic pfr_result_t step_receiver(input logic [7:0] b);
    pfr_result_t r;
    logic        done;
    int unsigned shift;
    r = '0;
    r.status = ST_BUSY;
    done = 1'b0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          rx_crc   = '0;
          rx_count = '0;
          rx_phase = PH_FROM;
        end
      end
      PH_FROM: begin
        rx_from  = b;
        rx_crc   = crc8_fold(rx_crc, b);
        rx_phase = PH_TO;
      end
      PH_TO: begin
        rx_to    = b;
        rx_crc   = crc8_fold(rx_crc, b);
        rx_phase = PH_CMD;
      end
      PH_CMD: begin
        rx_cmd   = b;
        rx_crc   = crc8_fold(rx_crc, b);
        rx_count = '0;
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        if (rx_count >= LEN_GROUPS) begin
          r.status = ST_LEN;
          done = 1'b1;
        end else begin
          shift = GROUP_W * rx_count;
          if (shift < LEN_W) begin
            rx_len = rx_len | (LEN_W'(b & GROUP_MASK) << shift);
          end
          rx_count = rx_count + 1'b1;
          rx_crc = crc8_fold(rx_crc, b);
          if ((b & MORE_BIT) == '0) begin
            rx_count = '0;
            rx_phase = (rx_len == '0) ? PH_CRC : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        r.data_valid = 1'b1;
        r.data_byte  = b;
        rx_count = rx_count + 1'b1;
        rx_crc = crc8_fold(rx_crc, b);
        if (rx_count == rx_len) begin
          rx_count = '0;
          rx_phase = PH_CRC;
        end
      end
      PH_CRC: begin
        rx_crc = crc8_fold(rx_crc, b);
        if (rx_crc != '0) begin
          r.status = ST_CRC;
          done = 1'b1;
        end else begin
          rx_phase = PH_STOP;
        end
      end
      default: begin
        r.status = (b == STOP_BYTE) ? ST_VALID : ST_STOP;
        done = 1'b1;
      end
    endcase
    if (!done && rx_phase == PH_HUNT) begin
      r.status = ST_IDLE;
    end
    r.from_addr      = rx_from;
    r.to_addr        = rx_to;
    r.command        = rx_cmd;
    r.payload_length = rx_len;
    if (done) begin
      clear_receiver();
    end
    return r;
  endfunction

  function automatic string fmt_result(input pfr_result_t r);
    return $sformatf("st=%0d from=%h to=%h cmd=%h len=%0d dv=%b db=%h", r.status,
                     r.from_addr, r.to_addr, r.command, r.payload_length,
                     r.data_valid, r.data_byte);
  endfunction

  task automatic note_failure(input string msg);
    n_fail++;
    if (n_fail <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  initial begin
    n_fail    = 0;
    n_checked = 0;
    n_good    = 0;
    n_bad     = 0;
    clear_receiver();
  end

  always @(posedge clk) begin
    pfr_result_t seen;
    pfr_result_t want;
    if (!rst_n) begin
      clear_receiver();
      status_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{status: pfr_status_t'(out_status), from_addr: out_from_addr,
                 to_addr: out_to_addr, command: out_command,
                 payload_length: out_payload_length, data_valid: out_data_valid,
                 data_byte: out_data_byte};
        n_checked++;
        if (status_due.size() == 0) begin
          note_failure({"unexpected result ", fmt_result(seen)});
        end else begin
          want = status_due.pop_front();
          if (seen !== want) begin
            note_failure({"expected ", fmt_result(want), " got ", fmt_result(seen)});
          end else if (want.status == ST_VALID) begin
            n_good++;
          end else if (want.status inside {ST_CRC, ST_STOP, ST_LEN}) begin
            n_bad++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        status_due.push_back(step_receiver(in_rx_byte));
      end
    end
    mismatches  <= n_fail;
    pending     <= status_due.size();
    checked     <= n_checked;
    frames_good <= n_good;
    frames_bad  <= n_bad;
  end

endmodule

[verif/packet_frame_receiver_crc8_tb.sv]
`timescale 1ns / 1ps

module packet_frame_receiver_crc8_tb;
  import pfr_pkg::*;
  import frame_crc_pkg::*;

  // random frame bytes to send after the directed frames
  localparam int RANDOM_BYTES = 750;
  // hang guard limit, leaves lots of room over the slowest legal run
  localparam int CYCLE_LIMIT  = 200000;

  // ways a generated frame can go wrong
  typedef enum int {
    FAULT_NONE,
    FAULT_CRC,
    FAULT_STOP,
    FAULT_LEN
  } frame_fault_t;

  logic clk        = 1'b0;
  logic rst_n      = 1'b0;
  logic in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_stall  = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_from_addr;
  logic [7:0]  out_to_addr;
  logic [7:0]  out_command;
  logic [20:0] out_payload_length;
  logic        out_data_valid;
  logic [7:0]  out_data_byte;

  int mismatches;
  int pending;
  int checked;
  int frames_good;
  int frames_bad;

  int cycles         = 0;
  int send_gap_pct   = 9;
  int recv_stall_pct = 76;
  int bytes_sent     = 0;
  int frame_bytes    = 0;

  packet_frame_receiver_crc8 uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_from_addr      (out_from_addr),
    .out_to_addr        (out_to_addr),
    .out_command        (out_command),
    .out_payload_length (out_payload_length),
    .out_data_valid     (out_data_valid),
    .out_data_byte      (out_data_byte)
  );

  // watches both channels, predicts every status and compares
  frame_status_checker status_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_from_addr      (out_from_addr),
    .out_to_addr        (out_to_addr),
    .out_command        (out_command),
    .out_payload_length (out_payload_length),
    .out_data_valid     (out_data_valid),
    .out_data_byte      (out_data_byte),
    .mismatches         (mismatches),
    .pending            (pending),
    .checked            (checked),
    .frames_good        (frames_good),
    .frames_bad         (frames_bad)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, pending);
      $display("packet_frame_receiver_crc8 verification failed");
      $finish;
    end
  end

  // one raw byte request; random idle cycles ahead of it, then hold until taken
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // builds a whole frame and sends it byte by byte
  // pad_len stretches the length field to all groups with zero high groups
  task automatic send_frame(input frame_fault_t fault, input int unsigned len,
                            input logic pad_len, input logic [7:0] src,
                            input logic [7:0] dst, input logic [7:0] op);
    logic [7:0]  frame_q[$];
    logic [7:0]  crc;
    logic [7:0]  b;
    int unsigned rest;
    int unsigned groups;
    frame_q = {START_BYTE, src, dst, op};
    if (fault == FAULT_LEN) begin
      // every allowed length byte says more follows, then one too many
      repeat (LEN_GROUPS) frame_q.push_back(8'($urandom) | MORE_BIT);
      frame_q.push_back(8'($urandom));
    end else begin
      groups = 1;
      while ((len >> (GROUP_W * groups)) != 0) groups++;
      if (pad_len) begin
        groups = LEN_GROUPS;
      end
      rest = len;
      for (int g = 0; g < groups; g++) begin
        b = 8'(rest) & GROUP_MASK;
        if (g < groups - 1) begin
          b = b | MORE_BIT;
        end
        frame_q.push_back(b);
        rest = rest >> GROUP_W;
      end
      repeat (len) frame_q.push_back(8'($urandom));
      // crc over from byte onward; appending the running value zeroes the residue
      crc = '0;
      for (int i = 1; i < frame_q.size(); i++) begin
        crc = crc8_fold(crc, frame_q[i]);
      end
      if (fault == FAULT_CRC) begin
        crc = crc ^ 8'($urandom_range(1, 255));
      end
      frame_q.push_back(crc);
      // after a crc error the stop byte is hunted over
      b = STOP_BYTE;
      if (fault == FAULT_STOP) begin
        b = 8'($urandom);
        if (b == STOP_BYTE) begin
          b = ~b;
        end
      end
      frame_q.push_back(b);
    end
    frame_bytes += frame_q.size();
    foreach (frame_q[i]) push_byte(frame_q[i]);
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;
    int          target;
    frame_fault_t fault;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: header extremes, one-byte payload, crc error with trailing stop,
    // stop error with padded zero length, too many length bytes
    send_frame(FAULT_NONE, 1, 1'b0, 8'h00, 8'hFF, 8'h7F);
    send_frame(FAULT_CRC,  0, 1'b0, 8'hFF, 8'h00, 8'h80);
    send_frame(FAULT_STOP, 0, 1'b1, 8'h55, 8'hAA, 8'hFF);
    send_frame(FAULT_LEN,  0, 1'b0, 8'hAA, 8'h55, 8'h00);

    // random: mostly well formed frames, some faulty ones, some line noise
    target = frame_bytes + RANDOM_BYTES;
    while (frame_bytes < target) begin
      // idling schedule: sender light / receiver heavy, swapped, then none
      if (target - frame_bytes > (2 * RANDOM_BYTES) / 3) begin
        send_gap_pct   = 9;
        recv_stall_pct = 76;
      end else if (target - frame_bytes > RANDOM_BYTES / 3) begin
        send_gap_pct   = 76;
        recv_stall_pct = 9;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise burst, sometimes with a stray start byte that opens a bogus frame
        repeat ($urandom_range(1, 4)) begin
          push_byte(($urandom_range(0, 5) == 0) ? START_BYTE : 8'($urandom));
        end
      end else begin
        if (pick < 70) fault = FAULT_NONE;
        else if (pick < 79) fault = FAULT_CRC;
        else if (pick < 88) fault = FAULT_STOP;
        else fault = FAULT_LEN;
        // mostly short payloads, a few needing two length groups
        pick = $urandom_range(0, 99);
        if (pick < 80) len = $urandom_range(0, 8);
        else if (pick < 97) len = $urandom_range(9, 40);
        else len = $urandom_range(128, 300);
        send_frame(fault, len, ($urandom_range(0, 3) == 0),
                   8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    in_valid <= 1'b0;

    // drain, then keep clocking for anything the block still emits
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes (%0d in frames), checked %0d status results",
             bytes_sent, frame_bytes, checked);
    $display("frames closed: %0d good, %0d with crc, stop or length errors",
             frames_good, frames_bad);
    if (pending != 0) begin
      $display("%0d expected results never arrived", pending);
    end
    if (mismatches == 0 && pending == 0) begin
      $display("packet_frame_receiver_crc8 verification clean");
    end else begin
      $display("packet_frame_receiver_crc8 verification failed");
    end
    $finish;
  end

endmodule

[files.f]
design/pfr_pkg.sv
design/pfr_crc8.sv
design/pfr_parser.sv
design/packet_frame_receiver_crc8.sv
design/pfr_checker.sv
verif/frame_status_checker.sv
verif/packet_frame_receiver_crc8_tb.sv
